FILE: src/bge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bge_pkg
// Shared types and character codes for the bracket group extractor.
// ----------------------------------------------------------------------------
package bge_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAREN   = 2'd0;
  localparam kind_t KIND_BRACKET = 2'd1;
  localparam kind_t KIND_BRACE   = 2'd2;

  localparam logic [7:0] CHAR_OPEN_PAREN    = 8'h28;
  localparam logic [7:0] CHAR_CLOSE_PAREN   = 8'h29;
  localparam logic [7:0] CHAR_OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE_BRACKET = 8'h5D;
  localparam logic [7:0] CHAR_OPEN_BRACE    = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE_BRACE   = 8'h7D;
  localparam logic [7:0] CHAR_SPACE         = 8'h20;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_CLOSE = 2'd2
  } char_class_t;

  typedef struct packed {
    logic [7:0] plane_char;
    logic       group_start;
    kind_t      group_kind;
    logic       in_group;
    logic       error;
  } result_t;

endpackage
`default_nettype wire

FILE: src/bracket_group_extractor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_group_extractor_top
// Bracket nesting tracker that cleans a text plane and marks top-level groups.
// ----------------------------------------------------------------------------
// One character is taken per beat; its result leaves from an output register.
// A new character can be taken every cycle while in_stall is low. The stack of
// open bracket kinds is a shift stack of STACK_DEPTH entries, so a push or a
// pop is done within the same cycle as the character that causes it. A skid
// entry beside the output register keeps in_stall a registered signal, so
// the input side stalls from the cycle after a beat is taken while the
// output register is held by out_stall, until that register drains.
// After an unmatched or mismatched close, or an open with the stack full,
// every result carries out_error set with the other fields zero until reset.
// ----------------------------------------------------------------------------
module bracket_group_extractor_top #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_plane_char,
  output logic            out_group_start,
  output logic [1:0]      out_group_kind,
  output logic            out_in_group,
  output logic            out_error
);

  bge_pkg::result_t core_result;
  bge_pkg::result_t out_data;
  logic             accept;

  assign accept = in_valid && !in_stall;

  bge_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .char_in (in_char_in),
    .result  (core_result)
  );

  bge_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (core_result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_plane_char  = out_data.plane_char;
  assign out_group_start = out_data.group_start;
  assign out_group_kind  = out_data.group_kind;
  assign out_in_group    = out_data.in_group;
  assign out_error       = out_data.error;

endmodule
`default_nettype wire

FILE: src/bge_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bge_core
// Bracket stack and per-character result logic, one character per beat.
// ----------------------------------------------------------------------------
module bge_core #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      char_in,
  output bge_pkg::result_t     result
);

  localparam int DepthW = $clog2(STACK_DEPTH + 1);

  // shift stack: entry 0 is the top of stack
  bge_pkg::kind_t stack_r   [STACK_DEPTH];
  bge_pkg::kind_t stack_nxt [STACK_DEPTH];
  logic [DepthW-1:0] depth_r, depth_nxt;
  logic              err_r, err_nxt;

  bge_pkg::char_class_t cls;
  bge_pkg::kind_t       kind;
  logic                 push, pop, fail;
  logic [DepthW-1:0]    depth_new;

  always_comb begin
    case (char_in)
      bge_pkg::CHAR_OPEN_PAREN: begin
        cls = bge_pkg::CLS_OPEN;  kind = bge_pkg::KIND_PAREN;
      end
      bge_pkg::CHAR_OPEN_BRACKET: begin
        cls = bge_pkg::CLS_OPEN;  kind = bge_pkg::KIND_BRACKET;
      end
      bge_pkg::CHAR_OPEN_BRACE: begin
        cls = bge_pkg::CLS_OPEN;  kind = bge_pkg::KIND_BRACE;
      end
      bge_pkg::CHAR_CLOSE_PAREN: begin
        cls = bge_pkg::CLS_CLOSE; kind = bge_pkg::KIND_PAREN;
      end
      bge_pkg::CHAR_CLOSE_BRACKET: begin
        cls = bge_pkg::CLS_CLOSE; kind = bge_pkg::KIND_BRACKET;
      end
      bge_pkg::CHAR_CLOSE_BRACE: begin
        cls = bge_pkg::CLS_CLOSE; kind = bge_pkg::KIND_BRACE;
      end
      default: begin
        cls = bge_pkg::CLS_OTHER; kind = bge_pkg::KIND_PAREN;
      end
    endcase
  end

  always_comb begin
    push = 1'b0;
    pop  = 1'b0;
    fail = 1'b0;
    if (!err_r) begin
      case (cls)
        bge_pkg::CLS_OPEN: begin
          if (depth_r == DepthW'(STACK_DEPTH)) fail = 1'b1;
          else                                 push = 1'b1;
        end
        bge_pkg::CLS_CLOSE: begin
          if (depth_r == '0 || stack_r[0] != kind) fail = 1'b1;
          else                                     pop  = 1'b1;
        end
        default: ;
      endcase
    end
    depth_new = push ? depth_r + 1'b1 : (pop ? depth_r - 1'b1 : depth_r);
  end

  always_comb begin
    if (err_r || fail) begin
      result = '0;
      result.error = 1'b1;
    end else begin
      result.plane_char  = (depth_new == '0 && !pop) ? char_in : bge_pkg::CHAR_SPACE;
      result.group_start = push && (depth_r == '0);
      result.group_kind  = (push && depth_r == '0) ? kind : bge_pkg::KIND_PAREN;
      result.in_group    = (depth_new != '0);
      result.error       = 1'b0;
    end
  end

  always_comb begin
    depth_nxt = depth_r;
    err_nxt   = err_r;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_nxt[i] = stack_r[i];
    end
    if (accept) begin
      depth_nxt = depth_new;
      err_nxt   = err_r | fail;
      if (push) begin
        stack_nxt[0] = kind;
        for (int i = 1; i < STACK_DEPTH; i++) begin
          stack_nxt[i] = stack_r[i-1];
        end
      end else if (pop) begin
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
          stack_nxt[i] = stack_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_r[i] <= stack_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DepthW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error flag cleared without reset");

  a_frozen_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> $stable(depth_r))
    else $error("stack moved after error");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (result.error && result.plane_char == '0 && !result.in_group))
    else $error("result not discarded after error");
`endif

endmodule
`default_nettype wire

FILE: src/bge_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bge_skid
// Output register with one skid entry so the input stall is registered.
// ----------------------------------------------------------------------------
module bge_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bge_pkg::result_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bge_pkg::result_t       out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  bge_pkg::result_t out_data_r, out_data_nxt;
  bge_pkg::result_t skid_data_r, skid_data_nxt;
  logic             accept;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      // output slot free this cycle: skid entry drains first
      out_valid_nxt  = skid_valid_r || accept;
      out_data_nxt   = skid_valid_r ? skid_data_r : in_data;
      skid_valid_nxt = 1'b0;
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && accept) |=> skid_valid_r)
    else $error("beat lost while output stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_stall) |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid entry overwritten while stalled");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bracket group extractor.
// ----------------------------------------------------------------------------
// Feeds short directed text, then long runs of balanced bracket text with
// random content. At least one run nests down to the full stack depth.
// The run closes with one error case, picked at random: an unmatched
// close, a mismatched close or a stack overflow. Noise follows it, to
// check that the error state stays frozen. A scoreboard tracks the
// nesting of every accepted character and compares each result beat,
// field by field. Both sides idle at random but for characters 500 to 699.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STACK_DEPTH  = 32;
  localparam int RANDOM_CHARS = 1200;
  localparam int CYCLE_LIMIT  = 200000;

  // expected plane output, tracked from the accepted characters
  class plane_scoreboard;
    bge_pkg::kind_t   open_kinds[STACK_DEPTH];
    int               nest_depth;
    bit               err_seen;
    bge_pkg::result_t pending[$];
    int               fails;

    function new();
      nest_depth = 0;
      err_seen   = 1'b0;
      fails      = 0;
    endfunction

    function bge_pkg::result_t predict(logic [7:0] c);
      bge_pkg::result_t     r;
      bge_pkg::char_class_t cls;
      bge_pkg::kind_t       k;
      bit                   start;
      bit                   closing;
      start   = 1'b0;
      closing = 1'b0;
      r       = '0;
      r.error = 1'b1;
      if (err_seen) return r;
      cls = bge_pkg::CLS_OTHER;
      k   = bge_pkg::KIND_PAREN;
      case (c)
        bge_pkg::CHAR_OPEN_PAREN: begin
          cls = bge_pkg::CLS_OPEN;  k = bge_pkg::KIND_PAREN;
        end
        bge_pkg::CHAR_OPEN_BRACKET: begin
          cls = bge_pkg::CLS_OPEN;  k = bge_pkg::KIND_BRACKET;
        end
        bge_pkg::CHAR_OPEN_BRACE: begin
          cls = bge_pkg::CLS_OPEN;  k = bge_pkg::KIND_BRACE;
        end
        bge_pkg::CHAR_CLOSE_PAREN: begin
          cls = bge_pkg::CLS_CLOSE; k = bge_pkg::KIND_PAREN;
        end
        bge_pkg::CHAR_CLOSE_BRACKET: begin
          cls = bge_pkg::CLS_CLOSE; k = bge_pkg::KIND_BRACKET;
        end
        bge_pkg::CHAR_CLOSE_BRACE: begin
          cls = bge_pkg::CLS_CLOSE; k = bge_pkg::KIND_BRACE;
        end
        default: ;
      endcase
      if (cls == bge_pkg::CLS_OPEN) begin
        if (nest_depth >= STACK_DEPTH) begin
          err_seen = 1'b1;
          return r;
        end
        start = (nest_depth == 0);
        open_kinds[nest_depth] = k;
        nest_depth++;
      end else if (cls == bge_pkg::CLS_CLOSE) begin
        if (nest_depth == 0 || open_kinds[nest_depth-1] != k) begin
          err_seen = 1'b1;
          return r;
        end
        nest_depth--;
        closing = 1'b1;
      end
      r.plane_char  = (nest_depth == 0 && !closing) ? c : bge_pkg::CHAR_SPACE;
      r.group_start = start;
      r.group_kind  = start ? k : bge_pkg::KIND_PAREN;
      r.in_group    = (nest_depth != 0);
      r.error       = 1'b0;
      return r;
    endfunction

    function void note_char(logic [7:0] c);
      pending = {pending, predict(c)};
    endfunction

    function void check_result(bge_pkg::result_t got);
      bge_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.plane_char !== want.plane_char) begin
        $display("%0t: plane_char expected %h actual %h", $time,
                 want.plane_char, got.plane_char);
        fails++;
      end
      if (got.group_start !== want.group_start) begin
        $display("%0t: group_start expected %b actual %b", $time,
                 want.group_start, got.group_start);
        fails++;
      end
      if (got.group_kind !== want.group_kind) begin
        $display("%0t: group_kind expected %0d actual %0d", $time,
                 want.group_kind, got.group_kind);
        fails++;
      end
      if (got.in_group !== want.in_group) begin
        $display("%0t: in_group expected %b actual %b", $time,
                 want.in_group, got.in_group);
        fails++;
      end
      if (got.error !== want.error) begin
        $display("%0t: error expected %b actual %b", $time, want.error, got.error);
        fails++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_char_in = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_plane_char;
  logic       out_group_start;
  logic [1:0] out_group_kind;
  logic       out_in_group;
  logic       out_error;

  plane_scoreboard  sb = new();
  bge_pkg::result_t out_beat;
  bit               idle_on = 1'b1;
  int               chars_sent = 0;
  int               cycles = 0;
  bge_pkg::kind_t   gen_kinds[$];

  bracket_group_extractor_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_plane_char (out_plane_char),
    .out_group_start(out_group_start),
    .out_group_kind (out_group_kind),
    .out_in_group   (out_in_group),
    .out_error      (out_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign out_beat = {out_plane_char, out_group_start, out_group_kind,
                     out_in_group, out_error};

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_char(in_char_in);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_beat);
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] open_char(bge_pkg::kind_t k);
    case (k)
      bge_pkg::KIND_BRACKET: return bge_pkg::CHAR_OPEN_BRACKET;
      bge_pkg::KIND_BRACE:   return bge_pkg::CHAR_OPEN_BRACE;
      default:               return bge_pkg::CHAR_OPEN_PAREN;
    endcase
  endfunction

  function automatic logic [7:0] close_char(bge_pkg::kind_t k);
    case (k)
      bge_pkg::KIND_BRACKET: return bge_pkg::CHAR_CLOSE_BRACKET;
      bge_pkg::KIND_BRACE:   return bge_pkg::CHAR_CLOSE_BRACE;
      default:               return bge_pkg::CHAR_CLOSE_PAREN;
    endcase
  endfunction

  function automatic bge_pkg::kind_t random_kind();
    return bge_pkg::kind_t'($urandom_range(2));
  endfunction

  function automatic logic [7:0] random_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == bge_pkg::CHAR_OPEN_PAREN || c == bge_pkg::CHAR_CLOSE_PAREN ||
               c == bge_pkg::CHAR_OPEN_BRACKET || c == bge_pkg::CHAR_CLOSE_BRACKET ||
               c == bge_pkg::CHAR_OPEN_BRACE || c == bge_pkg::CHAR_CLOSE_BRACE);
    return c;
  endfunction

  task automatic send_char(input logic [7:0] c);
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    // payload holds while stalled
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_open(input bge_pkg::kind_t k);
    gen_kinds = {gen_kinds, k};
    send_char(open_char(k));
  endtask

  task automatic send_close();
    bge_pkg::kind_t k;
    k = gen_kinds.pop_back();
    send_char(close_char(k));
  endtask

  task automatic deep_dive();
    while (gen_kinds.size() < STACK_DEPTH) begin
      send_open(random_kind());
      if ($urandom_range(3) == 0) send_char(random_plain());
    end
    while (gen_kinds.size() > 0) send_close();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int   r;
    int   top_k;
    int   err_case;
    bit   drained_mid;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain extremes, every kind, nesting and a top-level space
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(bge_pkg::CHAR_SPACE);
    send_open(bge_pkg::KIND_PAREN);
    send_char(8'h78);
    send_close();
    send_open(bge_pkg::KIND_BRACKET);
    send_open(bge_pkg::KIND_BRACE);
    send_char(8'h00);
    send_close();
    send_close();
    send_open(bge_pkg::KIND_BRACE);
    send_open(bge_pkg::KIND_PAREN);
    send_char(8'hFF);
    send_close();
    send_close();
    send_open(bge_pkg::KIND_PAREN);
    send_open(bge_pkg::KIND_PAREN);
    send_char(bge_pkg::CHAR_SPACE);
    send_close();
    send_close();
    send_open(bge_pkg::KIND_BRACKET);
    send_close();
    send_char(8'h7A);

    // full-depth nesting once for sure
    deep_dive();

    while (chars_sent < RANDOM_CHARS) begin
      if (!drained_mid && chars_sent >= 300) begin
        drained_mid = 1'b1;
        wait_drained();
      end
      idle_on = !(chars_sent >= 500 && chars_sent < 700);
      r = $urandom_range(99);
      if (gen_kinds.size() == 0) begin
        if (r < 2) deep_dive();
        else if (r < 55) send_open(random_kind());
        else send_char(random_plain());
      end else begin
        if (r < 35 && gen_kinds.size() < STACK_DEPTH) send_open(random_kind());
        else if (r < 68) send_close();
        else send_char(random_plain());
      end
    end
    idle_on = 1'b1;

    // one error case per run, since the error state holds until reset
    err_case = $urandom_range(2);
    case (err_case)
      0: begin
        while (gen_kinds.size() > 0) send_close();
        send_char(close_char(random_kind()));
      end
      1: begin
        if (gen_kinds.size() < STACK_DEPTH) send_open(random_kind());
        top_k = int'(gen_kinds[$]);
        send_char(close_char(bge_pkg::kind_t'((top_k + 1 + $urandom_range(1)) % 3)));
      end
      default: begin
        while (gen_kinds.size() < STACK_DEPTH) send_open(random_kind());
        send_char(open_char(random_kind()));
      end
    endcase

    // frozen state: any byte now gives only the error flag
    repeat (24) begin
      if ($urandom_range(1) == 0) send_char(8'($urandom_range(255)));
      else if ($urandom_range(1) == 0) send_char(open_char(random_kind()));
      else send_char(close_char(random_kind()));
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bge_pkg.sv
src/bge_core.sv
src/bge_skid.sv
src/bracket_group_extractor_top.sv
tb/sv/tb_top.sv
